FILE: rtl/lgs_pkg.sv
// ============================================================================
// lgs_pkg: shared constants, types and helpers for the Life grid block
// Grid geometry, item kinds, register indexes and the size clamps.
// ============================================================================
package lgs_pkg;

  localparam int MaxColumns = 64;
  localparam int MaxRows    = 64;

  localparam int ColW  = MaxColumns;
  localparam int RowW  = $clog2(MaxRows);
  localparam int CfgW  = 7;
  localparam int StepW = $clog2(MaxRows + 3);
  localparam int KindW = 2;

  typedef enum logic [KindW-1:0] {
    KindWrite = 2'd0,
    KindRead  = 2'd1,
    KindGen   = 2'd2
  } kind_e;

  localparam logic CfgColumns = 1'b0;
  localparam logic CfgRows    = 1'b1;

  localparam logic [CfgW-1:0] ResetColumns = CfgW'(MaxColumns);
  localparam logic [CfgW-1:0] ResetRows    = CfgW'(MaxRows);
  localparam logic [CfgW-1:0] MinSize      = CfgW'(3);

  // Values below three are taken as three, values above the limit as the limit.
  function automatic logic [CfgW-1:0] clamp_size(logic [CfgW-1:0] v, logic [CfgW-1:0] hi);
    logic [CfgW-1:0] r;
    if (v < MinSize) begin
      r = MinSize;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [ColW-1:0] width_mask(logic [CfgW-1:0] w);
    logic [ColW-1:0] m;
    for (int i = 0; i < ColW; i++) begin
      m[i] = (CfgW'(i) < w);
    end
    return m;
  endfunction

endpackage

FILE: rtl/lgs_in_if.sv
// ============================================================================
// lgs_in_if: request channel of the Life grid block
// Carries the item kind, the addressed row and the row bits to write.
// ============================================================================
interface lgs_in_if;
  logic                     valid;
  logic                     ready;
  logic [lgs_pkg::KindW-1:0] kind;
  logic [lgs_pkg::RowW-1:0]  row_index;
  logic [lgs_pkg::ColW-1:0]  row_bits;

  modport source (output valid, output kind, output row_index, output row_bits,
                  input ready);
  modport sink   (input valid, input kind, input row_index, input row_bits,
                  output ready);
endinterface

FILE: rtl/lgs_out_if.sv
// ============================================================================
// lgs_out_if: response channel of the Life grid block
// Carries the row read back and the completion flag.
// ============================================================================
interface lgs_out_if;
  logic                    valid;
  logic                    ready;
  logic [lgs_pkg::ColW-1:0] row_data;
  logic                    finished;

  modport source (output valid, output row_data, output finished, input ready);
  modport sink   (input valid, input row_data, input finished, output ready);
endinterface

FILE: rtl/lgs_ram.sv
// ============================================================================
// lgs_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ============================================================================
module lgs_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/lgs_row_rule.sv
// ============================================================================
// lgs_row_rule: B3/S23 update of one row
// Counts the eight toroidal neighbours bit-sliced and applies the rule.
// ============================================================================
module lgs_row_rule (
  input  logic [lgs_pkg::ColW-1:0] up_i,
  input  logic [lgs_pkg::ColW-1:0] cur_i,
  input  logic [lgs_pkg::ColW-1:0] down_i,
  input  logic [lgs_pkg::CfgW-1:0] width_i,
  input  logic [lgs_pkg::ColW-1:0] mask_i,
  output logic [lgs_pkg::ColW-1:0] next_o
);

  localparam int ColW  = lgs_pkg::ColW;
  localparam int ColIW = $clog2(ColW);

  logic [lgs_pkg::CfgW-1:0] wm1_full;
  logic [ColIW-1:0]         wm1;
  logic [ColW-1:0]          nb [8];
  logic [ColW-1:0]          s0, s1, s2, c0, c1;

  assign wm1_full = width_i - lgs_pkg::CfgW'(1);
  assign wm1      = wm1_full[ColIW-1:0];

  // Inputs are already masked, so the wrapped bit is a single column.
  function automatic logic [ColW-1:0] from_left(logic [ColW-1:0] x, logic [ColIW-1:0] top,
                                                logic [ColW-1:0] m);
    logic [ColW-1:0] r;
    r = {x[ColW-2:0], 1'b0};
    r[0] = x[top];
    return r & m;
  endfunction

  function automatic logic [ColW-1:0] from_right(logic [ColW-1:0] x, logic [ColIW-1:0] top,
                                                 logic [ColW-1:0] m);
    logic [ColW-1:0] r;
    r = {1'b0, x[ColW-1:1]};
    r[top] = r[top] | x[0];
    return r & m;
  endfunction

  always_comb begin
    nb[0] = up_i;
    nb[1] = from_left(up_i, wm1, mask_i);
    nb[2] = from_right(up_i, wm1, mask_i);
    nb[3] = from_left(cur_i, wm1, mask_i);
    nb[4] = from_right(cur_i, wm1, mask_i);
    nb[5] = down_i;
    nb[6] = from_left(down_i, wm1, mask_i);
    nb[7] = from_right(down_i, wm1, mask_i);
  end

  // Three-bit count per column; a count of eight wraps to zero, which is harmless.
  always_comb begin
    s0 = '0;
    s1 = '0;
    s2 = '0;
    c0 = '0;
    c1 = '0;
    for (int k = 0; k < 8; k++) begin
      c0 = s0 & nb[k];
      s0 = s0 ^ nb[k];
      c1 = s1 & c0;
      s1 = s1 ^ c0;
      s2 = s2 ^ c1;
    end
  end

  assign next_o = s1 & ~s2 & (s0 | cur_i) & mask_i;

endmodule

FILE: rtl/life_grid_generation_step.sv
// ============================================================================
// life_grid_generation_step: Conway B3/S23 grid on a torus
// Row-per-word grid in a RAM; writes, reads and whole-grid generations.
// ============================================================================
//
//   channel   direction  content
//   item_i    in         kind, row_index, row_bits
//   result_o  out        row_data, finished
//   cfg       in         cfg_we_i, cfg_index_i, cfg_data_i (columns, rows)
//
// A row write and an unused kind go to StFin once accepted; a row read waits
// in StRead for the RAM data first. A generation over the effective height h
// reads the wrap row and then one row per cycle through the single RAM read
// port, and two further steps cover the read latency and write the last row.
// Reset clears the per-row valid bits, so the grid reads as dead at once.
// A new item is accepted while the previous result still waits in the output
// register; a stalled output holds a later result in StFin, blocking input.
// ============================================================================
module life_grid_generation_step (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  lgs_in_if.sink                   item_i,
  lgs_out_if.source                result_o,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [lgs_pkg::CfgW-1:0] cfg_data_i
);

  localparam int ColW  = lgs_pkg::ColW;
  localparam int RowW  = lgs_pkg::RowW;
  localparam int CfgW  = lgs_pkg::CfgW;
  localparam int StepW = lgs_pkg::StepW;

  // One-hot sequencer states.
  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StRead = 4'b0010,
    StGen  = 4'b0100,
    StFin  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [CfgW-1:0] columns_q, rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= lgs_pkg::ResetColumns;
      rows_q    <= lgs_pkg::ResetRows;
    end else if (cfg_we_i) begin
      if (cfg_index_i == lgs_pkg::CfgColumns) begin
        columns_q <= cfg_data_i;
      end else begin
        rows_q <= cfg_data_i;
      end
    end
  end

  // Effective grid size and the column mask, stable across a generation if the
  // user changes configuration only while idle; the block does not enforce it.
  logic [CfgW-1:0]  width_eff, height_eff;
  logic [ColW-1:0]  col_mask;
  logic [StepW-1:0] h_ext, last_step, last_row;

  assign width_eff  = lgs_pkg::clamp_size(columns_q, lgs_pkg::ResetColumns);
  assign height_eff = lgs_pkg::clamp_size(rows_q, lgs_pkg::ResetRows);
  assign col_mask   = lgs_pkg::width_mask(width_eff);
  assign h_ext      = StepW'(height_eff);
  assign last_step  = h_ext + StepW'(2);
  assign last_row   = h_ext - StepW'(1);

  // Input handshake: the sequencer takes a new item whenever it is idle.
  logic           acc_in;
  lgs_pkg::kind_e kind_in;

  assign item_i.ready = (state_q == StIdle);
  assign acc_in       = item_i.valid && item_i.ready;
  assign kind_in      = lgs_pkg::kind_e'(item_i.kind);

  // Grid RAM and per-row valid bits. A row never written since reset reads
  // as all dead, which stands in for clearing the memory.
  localparam int MaxRowsW = lgs_pkg::MaxRows;

  logic            ram_we, ram_re;
  logic [RowW-1:0] ram_waddr, ram_raddr;
  logic [ColW-1:0] ram_wdata, ram_rdata, row_rd;
  logic [MaxRowsW-1:0] vld_q;
  logic            rvld_q;

  lgs_ram #(
    .Width (ColW),
    .Depth (lgs_pkg::MaxRows)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rvld_q <= vld_q[ram_raddr];
      end
    end
  end

  assign row_rd = rvld_q ? ram_rdata : '0;

  // Generation walk. Step 0 reads the last row (the row above row 0),
  // steps 1 to h read rows 0 to h-1 in order. Read data lands a step later:
  // step 1 primes the row above, step 2 primes the current row and keeps
  // the old row 0 for the wrap, and each later step writes the row above
  // the one just read. The final step uses the kept row 0 as the row below.
  // Row r+1 is always read before row r is written, so no forwarding is
  // needed; the write and read addresses of one cycle always differ.
  logic [StepW-1:0] step_q;
  logic [ColW-1:0]  prev_q, cur_q, first_q;
  logic [ColW-1:0]  down_row, next_row;
  logic [StepW-1:0] rd_step, wr_step;
  logic             gen_last;

  assign gen_last = (step_q == last_step);
  assign down_row = gen_last ? first_q : (row_rd & col_mask);
  assign rd_step  = step_q - StepW'(1);
  assign wr_step  = gen_last ? last_row : (step_q - StepW'(3));

  lgs_row_rule u_row_rule (
    .up_i    (prev_q),
    .cur_i   (cur_q),
    .down_i  (down_row),
    .width_i (width_eff),
    .mask_i  (col_mask),
    .next_o  (next_row)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = '0;
    ram_raddr = '0;
    ram_wdata = '0;
    case (state_q)
      StIdle: begin
        if (acc_in) begin
          case (kind_in)
            lgs_pkg::KindWrite: begin
              ram_we    = 1'b1;
              ram_waddr = item_i.row_index;
              ram_wdata = item_i.row_bits;
            end
            lgs_pkg::KindRead: begin
              ram_re    = 1'b1;
              ram_raddr = item_i.row_index;
            end
            default: begin
            end
          endcase
        end
      end
      StGen: begin
        if (step_q == '0) begin
          ram_re    = 1'b1;
          ram_raddr = last_row[RowW-1:0];
        end else if (step_q <= h_ext) begin
          ram_re    = 1'b1;
          ram_raddr = rd_step[RowW-1:0];
        end
        if (step_q >= StepW'(3)) begin
          ram_we    = 1'b1;
          ram_waddr = wr_step[RowW-1:0];
          ram_wdata = next_row;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StGen) begin
      if (step_q == StepW'(1)) begin
        prev_q <= row_rd & col_mask;
      end else if (step_q == StepW'(2)) begin
        cur_q   <= row_rd & col_mask;
        first_q <= row_rd & col_mask;
      end else if (step_q >= StepW'(3) && !gen_last) begin
        prev_q <= cur_q;
        cur_q  <= down_row;
      end
    end
  end

  // Sequencer and the pending result of the item in flight.
  logic [ColW-1:0] res_data_q, res_data_d;
  logic            res_fin_q, res_fin_d;
  logic [StepW-1:0] step_d;
  logic            out_load;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    res_data_d = res_data_q;
    res_fin_d  = res_fin_q;
    case (state_q)
      StIdle: begin
        if (acc_in) begin
          res_data_d = '0;
          case (kind_in)
            lgs_pkg::KindWrite: begin
              res_fin_d = 1'b1;
              state_d   = StFin;
            end
            lgs_pkg::KindRead: begin
              state_d = StRead;
            end
            lgs_pkg::KindGen: begin
              step_d  = '0;
              state_d = StGen;
            end
            default: begin
              res_fin_d = 1'b0;
              state_d   = StFin;
            end
          endcase
        end
      end
      StRead: begin
        res_data_d = row_rd;
        res_fin_d  = 1'b1;
        state_d    = StFin;
      end
      StGen: begin
        step_d = step_q + StepW'(1);
        if (gen_last) begin
          res_data_d = '0;
          res_fin_d  = 1'b1;
          state_d    = StFin;
        end
      end
      StFin: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_data_q <= res_data_d;
    res_fin_q  <= res_fin_d;
  end

  // Output register: loaded from the finished item once it is empty or
  // being drained in the same cycle.
  logic            out_valid_q;
  logic [ColW-1:0] out_data_q;
  logic            out_fin_q;

  assign out_load = (state_q == StFin) && (!out_valid_q || result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= res_data_q;
      out_fin_q  <= res_fin_q;
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.row_data = out_data_q;
  assign result_o.finished = out_fin_q;

  // The walk never writes the row it reads in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("grid RAM read and write collide on one row");

  // The step counter stays within the walk for the configured height.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StGen) |-> (step_q <= last_step))
    else $error("generation step counter overran the grid height");

  // An accepted read moves to StRead in the next cycle to wait for the RAM data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_in && kind_in == lgs_pkg::KindRead) |=> (state_q == StRead))
    else $error("row read did not wait for RAM data");

  // A result is only loaded while the output register is free or draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |=> $stable(out_data_q))
    else $error("stalled result was overwritten");

endmodule

FILE: test/tb_top.sv
// ============================================================================
// tb_top: self-checking bench for the toroidal Life grid block
// Drives row writes, row reads and generations through the request channel,
// keeps its own copy of the grid to predict every result beat, and checks
// each beat on the response channel in order. Grid sizes are changed between
// phases through the configuration port, the extremes and the clamps among
// them.
// ============================================================================

// Scoreboard: a shadow copy of the grid and of the two size registers.
// Each accepted request is played against the shadow copy at once, and the
// result beat it should produce waits in a queue until the block sends it.
class grid_scoreboard;

  typedef struct {
    logic [lgs_pkg::ColW-1:0] row_data;
    logic                     finished;
  } row_result_t;

  logic [lgs_pkg::ColW-1:0] grid [lgs_pkg::MaxRows];
  logic [lgs_pkg::CfgW-1:0] width_reg;
  logic [lgs_pkg::CfgW-1:0] height_reg;
  row_result_t              awaited_rows [$];
  int                       errors;

  function new();
    foreach (grid[i]) grid[i] = '0;
    width_reg  = lgs_pkg::ResetColumns;
    height_reg = lgs_pkg::ResetRows;
    errors     = 0;
  endfunction

  // Sizes below three count as three, sizes above the limit as the limit.
  static function int effective_size(logic [lgs_pkg::CfgW-1:0] v, int limit);
    if (v < 3) return 3;
    if (v > limit) return limit;
    return int'(v);
  endfunction

  function int height();
    return effective_size(height_reg, lgs_pkg::MaxRows);
  endfunction

  function void set_register(logic idx, logic [lgs_pkg::CfgW-1:0] value);
    if (idx == lgs_pkg::CfgColumns) width_reg = value;
    else height_reg = value;
  endfunction

  // One B3/S23 generation over the used region, wrapping on both axes.
  // Every new row is formed from a snapshot of the old grid only.
  function void advance_generation();
    logic [lgs_pkg::ColW-1:0] old_grid [lgs_pkg::MaxRows];
    logic [lgs_pkg::ColW-1:0] new_row;
    int w, h, x, y, up, dn, lf, rt, count;
    w = effective_size(width_reg, lgs_pkg::MaxColumns);
    h = height();
    old_grid = grid;
    for (y = 0; y < h; y++) begin
      up = (y + h - 1) % h;
      dn = (y + 1) % h;
      new_row = '0;
      for (x = 0; x < w; x++) begin
        lf = (x + w - 1) % w;
        rt = (x + 1) % w;
        count = int'(old_grid[up][lf]) + int'(old_grid[up][x]) + int'(old_grid[up][rt])
              + int'(old_grid[y][lf]) + int'(old_grid[y][rt])
              + int'(old_grid[dn][lf]) + int'(old_grid[dn][x]) + int'(old_grid[dn][rt]);
        new_row[x] = (count == 3) || (count == 2 && old_grid[y][x]);
      end
      // Columns at or beyond the width come out cleared.
      grid[y] = new_row;
    end
  endfunction

  function void note_item(logic [lgs_pkg::KindW-1:0] kind, logic [lgs_pkg::RowW-1:0] idx,
                          logic [lgs_pkg::ColW-1:0] bits);
    row_result_t outcome;
    outcome.row_data = '0;
    outcome.finished = 1'b1;
    if (kind == lgs_pkg::KindWrite) begin
      grid[idx] = bits;
    end else if (kind == lgs_pkg::KindRead) begin
      outcome.row_data = grid[idx];
    end else if (kind == lgs_pkg::KindGen) begin
      advance_generation();
    end else begin
      // The unused kind does nothing and reports itself as not finished.
      outcome.finished = 1'b0;
    end
    awaited_rows.push_back(outcome);
  endfunction

  function void check_result(logic [lgs_pkg::ColW-1:0] row_data, logic finished);
    row_result_t oldest;
    if (awaited_rows.size() == 0) begin
      $display("%0t: result beat with no request outstanding, row_data %h finished %b",
               $time, row_data, finished);
      errors++;
      return;
    end
    oldest = awaited_rows.pop_front();
    if (row_data !== oldest.row_data) begin
      $display("%0t: row_data mismatch, expected %h, got %h", $time, oldest.row_data,
               row_data);
      errors++;
    end
    if (finished !== oldest.finished) begin
      $display("%0t: finished mismatch, expected %b, got %b", $time, oldest.finished,
               finished);
      errors++;
    end
  endfunction

  function int outstanding();
    return awaited_rows.size();
  endfunction

endclass

module tb_top;

  localparam int KindW   = lgs_pkg::KindW;
  localparam int RowW    = lgs_pkg::RowW;
  localparam int ColW    = lgs_pkg::ColW;
  localparam int CfgW    = lgs_pkg::CfgW;
  localparam int MaxRows = lgs_pkg::MaxRows;

  // The block defines no name for the fourth item kind, so the bench does.
  localparam logic [KindW-1:0] KindUnused = 2'd3;

  // Random part: fourteen phases of one hundred requests, each phase with its
  // own grid size.
  localparam int PhaseCount    = 14;
  localparam int ItemsPerPhase = 100;

  // Settling time after the last beat; this covers the tail of any request
  // that might still be in flight.
  localparam int DrainCycles = MaxRows + 40;

  // Long receiver hold-off used once to fill the block and back up the input.
  localparam int LongHoldCycles = 400;

  // The slowest correct run is about 1425 requests, each at worst a generation
  // plus a sender gap and a receiver stall, with the phase pauses on top; the
  // limit lies well above that.
  localparam int CycleLimit = 600000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_index_i;
  logic [CfgW-1:0]     cfg_data_i;

  lgs_in_if  item_if ();
  lgs_out_if result_if ();

  life_grid_generation_step i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_if.sink),
    .result_o    (result_if.source),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  grid_scoreboard grid_sb = new();

  // Shared knobs between the stimulus process and the receiver. When steady
  // is set neither side idles; a non-zero hold_off_cycles makes the receiver
  // keep ready low for that many cycles before its next beat.
  bit steady          = 1'b0;
  int hold_off_cycles = 0;
  int cycle_count     = 0;

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Draws an idle gap for one beat on either side.
  function automatic int idle_gap();
    if (steady) return 0;
    return $urandom_range(0, 6);
  endfunction

  // Row contents of varied density: empty, full, even, sparse and dense, so
  // that patterns both die out and keep evolving across generations.
  function automatic logic [ColW-1:0] random_row();
    logic [ColW-1:0] a, b, c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      4:       return a & b & c;
      5:       return a | b;
      default: return a;
    endcase
  endfunction

  // Offers one request and returns at the edge where it is accepted. The
  // valid line is only lowered when a gap is drawn, so back-to-back beats
  // keep it high without a second assignment in the same step.
  task automatic send_item(logic [KindW-1:0] kind, logic [RowW-1:0] idx,
                           logic [ColW-1:0] bits);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid     <= 1'b1;
    item_if.kind      <= kind;
    item_if.row_index <= idx;
    item_if.row_bits  <= bits;
    @(posedge clk_i);
    while (item_if.ready !== 1'b1) @(posedge clk_i);
    grid_sb.note_item(kind, idx, bits);
  endtask

  // Random request mix: mostly reads and writes, with enough generations to
  // keep the grid evolving. Row indexes favour the rows inside the height so
  // that reads see computed rows, but every row is reached.
  task automatic send_random_item();
    int               pick;
    logic [KindW-1:0] kind;
    logic [RowW-1:0]  idx;
    pick = $urandom_range(0, 99);
    if (pick < 40)      kind = lgs_pkg::KindWrite;
    else if (pick < 80) kind = lgs_pkg::KindRead;
    else if (pick < 95) kind = lgs_pkg::KindGen;
    else                kind = KindUnused;
    if ($urandom_range(0, 3) != 0) idx = RowW'($urandom_range(0, grid_sb.height() - 1));
    else idx = RowW'($urandom_range(0, MaxRows - 1));
    send_item(kind, idx, random_row());
  endtask

  // Stops offering requests and waits until every predicted beat has come
  // back, then lets the block settle so that it is truly idle.
  task automatic wait_drained();
    item_if.valid <= 1'b0;
    while (grid_sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes the column register and then the row register; only call when idle.
  task automatic configure(logic [CfgW-1:0] cols, logic [CfgW-1:0] rows);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= lgs_pkg::CfgColumns;
    cfg_data_i  <= cols;
    @(posedge clk_i);
    grid_sb.set_register(lgs_pkg::CfgColumns, cols);
    cfg_index_i <= lgs_pkg::CfgRows;
    cfg_data_i  <= rows;
    @(posedge clk_i);
    grid_sb.set_register(lgs_pkg::CfgRows, rows);
    cfg_we_i    <= 1'b0;
  endtask

  // Receiver: draws a stall before every beat, or the long hold-off when one
  // has been requested, then takes one result beat and checks it.
  initial begin : result_sink
    int stall;
    result_if.ready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = idle_gap();
      end
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      @(posedge clk_i);
      while (result_if.valid !== 1'b1) @(posedge clk_i);
      grid_sb.check_result(result_if.row_data, result_if.finished);
    end
  end

  // Stimulus: reset, a directed part, then the random phases.
  initial begin : stimulus
    int              phase;
    logic [CfgW-1:0] cols, rows;

    rst_ni            <= 1'b0;
    item_if.valid     <= 1'b0;
    item_if.kind      <= lgs_pkg::KindWrite;
    item_if.row_index <= '0;
    item_if.row_bits  <= '0;
    cfg_we_i          <= 1'b0;
    cfg_index_i       <= lgs_pkg::CfgColumns;
    cfg_data_i        <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset size of 64 x 64. The grid must read as dead
    // straight after reset, at both ends of the row range.
    send_item(lgs_pkg::KindRead, RowW'(0), '0);
    send_item(lgs_pkg::KindRead, RowW'(MaxRows - 1), '1);
    // Full and empty rows, and a row with only its outermost columns set so
    // that the column wrap is exercised at the full width.
    send_item(lgs_pkg::KindWrite, RowW'(0), '1);
    send_item(lgs_pkg::KindWrite, RowW'(MaxRows - 1), 64'h8000_0000_0000_0001);
    send_item(lgs_pkg::KindRead, RowW'(0), '0);
    send_item(lgs_pkg::KindRead, RowW'(MaxRows - 1), '0);
    // The unused kind must come back with a zero row and finished low.
    send_item(KindUnused, RowW'(MaxRows - 1), '1);
    send_item(lgs_pkg::KindWrite, RowW'(1), '0);
    // A glider well away from the other rows.
    send_item(lgs_pkg::KindWrite, RowW'(10), 64'h2);
    send_item(lgs_pkg::KindWrite, RowW'(11), 64'h4);
    send_item(lgs_pkg::KindWrite, RowW'(12), 64'h7);
    send_item(lgs_pkg::KindGen, RowW'(0), '0);
    send_item(lgs_pkg::KindRead, RowW'(0), '0);
    send_item(lgs_pkg::KindRead, RowW'(11), '0);
    send_item(lgs_pkg::KindRead, RowW'(MaxRows - 1), '0);

    // Sizes below the minimum: both registers clamp to a 3 x 3 torus. Row 0
    // full and rows 1 and 2 empty give survivors in row 0 and births in the
    // other two; columns above the width are cleared, while row 3 lies
    // outside the height and must keep its contents.
    wait_drained();
    configure(CfgW'(2), CfgW'(0));
    send_item(lgs_pkg::KindWrite, RowW'(0), '1);
    send_item(lgs_pkg::KindWrite, RowW'(1), '0);
    send_item(lgs_pkg::KindWrite, RowW'(2), '0);
    send_item(lgs_pkg::KindWrite, RowW'(3), '1);
    send_item(lgs_pkg::KindGen, RowW'(0), '0);
    send_item(lgs_pkg::KindRead, RowW'(0), '0);
    send_item(lgs_pkg::KindRead, RowW'(1), '0);
    send_item(lgs_pkg::KindRead, RowW'(2), '0);
    send_item(lgs_pkg::KindRead, RowW'(3), '0);

    // Random phases. The first ones walk through the extremes and the clamps
    // of both registers; the rest draw any value the register can hold.
    for (phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0:       begin cols = CfgW'(127); rows = CfgW'(127); end
        1:       begin cols = CfgW'(3);   rows = CfgW'(3);   end
        2:       begin cols = CfgW'(64);  rows = CfgW'(5);   end
        3:       begin cols = CfgW'(4);   rows = CfgW'(64);  end
        4:       begin cols = CfgW'(0);   rows = CfgW'(127); end
        5:       begin cols = CfgW'(65);  rows = CfgW'(1);   end
        6:       begin cols = CfgW'(63);  rows = CfgW'(63);  end
        7:       begin cols = CfgW'(7);   rows = CfgW'(9);   end
        default: begin
          cols = CfgW'($urandom_range(0, 127));
          rows = CfgW'($urandom_range(0, 127));
        end
      endcase
      // The sender pauses here until every outstanding beat has come back.
      wait_drained();
      configure(cols, rows);
      steady = (phase == 5 || phase == 10);
      // One long receiver stall while requests keep coming, so that the
      // output register and the pipeline fill and the input is held off.
      if (phase == 3) hold_off_cycles = LongHoldCycles;
      repeat (ItemsPerPhase) send_random_item();
    end

    wait_drained();
    if (grid_sb.outstanding() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, grid_sb.outstanding());
      grid_sb.errors++;
    end
    if (grid_sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lgs_pkg.sv
rtl/lgs_in_if.sv
rtl/lgs_out_if.sv
rtl/lgs_ram.sv
rtl/lgs_row_rule.sv
rtl/life_grid_generation_step.sv
test/tb_top.sv
